FILE: rtl/core/snq_pkg.sv
// Shared types, scale tables and helper functions of the scale note quantizer.
`timescale 1ns / 1ps
package snq_pkg;

    // Scale kind codes; anything else selects major
    localparam logic [2:0] KIND_MAJOR       = 3'd0;
    localparam logic [2:0] KIND_MINOR       = 3'd1;
    localparam logic [2:0] KIND_WHOLE       = 3'd2;
    localparam logic [2:0] KIND_OCTA        = 3'd3;
    localparam logic [2:0] KIND_PENTA_MAJOR = 3'd4;
    localparam logic [2:0] KIND_PENTA_MINOR = 3'd5;

    // Configuration register indexes
    localparam logic REG_ROOT_CLASS = 1'b0;
    localparam logic REG_SCALE_KIND = 1'b1;

    // Reciprocals for floor division by 5, 6 and 7
    localparam logic [7:0] RECIP_5 = 8'd205;   // >> 10
    localparam logic [7:0] RECIP_6 = 8'd171;   // >> 10
    localparam logic [8:0] RECIP_7 = 9'd293;   // >> 11
    localparam logic [7:0] RECIP_12 = 8'd43;   // >> 9, exact for 7-bit notes

    // Bias of 32 octaves keeps the dividend non-negative
    localparam logic [6:0] OCT_BIAS = 7'd32;

    localparam logic [6:0] NOTE_MAX = 7'd127;

    typedef logic [7:0][3:0] tone_row_t;

    typedef struct packed {
        logic [6:0]        note;
        logic signed [7:0] degrees;
    } note_item_t;

    typedef struct packed {
        logic [6:0]        note;
        logic signed [7:0] degrees;
        logic [3:0]        rel;
        logic              in_scale;
        logic [2:0]        kind;
        logic [3:0]        len;
    } class_data_t;

    typedef struct packed {
        logic              in_scale;
        logic [6:0]        quantized;
        logic signed [7:0] base;
        logic [2:0]        idx;
        logic signed [7:0] degrees;
        logic [2:0]        kind;
        logic [3:0]        len;
    } search_data_t;

    typedef struct packed {
        logic              in_scale;
        logic [6:0]        quantized;
        logic signed [7:0] base;
        logic [2:0]        kind;
        logic [3:0]        len;
        logic [8:0]        dividend;
        logic [6:0]        quo;
    } divide_data_t;

    typedef struct packed {
        logic       in_scale;
        logic [6:0] quantized;
        logic [6:0] stepped;
        logic [3:0] scale_size;
    } result_data_t;

    function automatic logic [3:0] scale_len(input logic [2:0] kind);
        logic [3:0] len;
        unique case (kind)
            KIND_MINOR:       len = 4'd7;
            KIND_WHOLE:       len = 4'd6;
            KIND_OCTA:        len = 4'd8;
            KIND_PENTA_MAJOR: len = 4'd5;
            KIND_PENTA_MINOR: len = 4'd5;
            default:          len = 4'd7;
        endcase
        return len;
    endfunction

    // Bit p set when pitch class p (relative to root) is in the scale
    function automatic logic [11:0] scale_mask(input logic [2:0] kind);
        logic [11:0] mask;
        unique case (kind)
            KIND_MINOR:       mask = 12'b0101_1010_1101;
            KIND_WHOLE:       mask = 12'b0101_0101_0101;
            KIND_OCTA:        mask = 12'b0110_1101_1011;
            KIND_PENTA_MAJOR: mask = 12'b0010_1001_0101;
            KIND_PENTA_MINOR: mask = 12'b0100_1010_1001;
            default:          mask = 12'b1010_1011_0101;
        endcase
        return mask;
    endfunction

    // Semitone offsets per degree, degree 0 in the low nibble
    function automatic tone_row_t scale_row(input logic [2:0] kind);
        tone_row_t row;
        unique case (kind)
            KIND_MINOR:
                row = {4'd0, 4'd10, 4'd8, 4'd7, 4'd5, 4'd3, 4'd2, 4'd0};
            KIND_WHOLE:
                row = {4'd0, 4'd0, 4'd10, 4'd8, 4'd6, 4'd4, 4'd2, 4'd0};
            KIND_OCTA:
                row = {4'd10, 4'd9, 4'd7, 4'd6, 4'd4, 4'd3, 4'd1, 4'd0};
            KIND_PENTA_MAJOR:
                row = {4'd0, 4'd0, 4'd0, 4'd9, 4'd7, 4'd4, 4'd2, 4'd0};
            KIND_PENTA_MINOR:
                row = {4'd0, 4'd0, 4'd0, 4'd10, 4'd7, 4'd5, 4'd3, 4'd0};
            default:
                row = {4'd0, 4'd11, 4'd9, 4'd7, 4'd5, 4'd4, 4'd2, 4'd0};
        endcase
        return row;
    endfunction

    function automatic logic [3:0] scale_tone(input logic [2:0] kind, input logic [2:0] pos);
        tone_row_t row;
        row = scale_row(kind);
        return row[pos];
    endfunction

    // Degree of a relative pitch class; 0 when absent
    function automatic logic [2:0] scale_index(input logic [2:0] kind, input logic [3:0] pc);
        tone_row_t  row;
        logic [3:0] len;
        logic [2:0] idx;
        row = scale_row(kind);
        len = scale_len(kind);
        idx = 3'd0;
        for (int i = 7; i >= 0; i--)
        begin
            if (row[i] == pc && 4'(i) < len)
            begin
                idx = 3'(i);
            end
        end
        return idx;
    endfunction

    // Note modulo 12 through a reciprocal
    function automatic logic [3:0] note_class(input logic [6:0] n);
        logic [12:0] prod;
        logic [3:0]  oq;
        logic [6:0]  rem;
        prod = 13'(n) * 13'(RECIP_12);
        oq   = prod[12:9];
        rem  = n - 7'(7'(oq) * 7'd12);
        return rem[3:0];
    endfunction

    // Fold 0..23 into 0..11
    function automatic logic [3:0] class_wrap(input logic [4:0] v);
        logic [4:0] w;
        w = (v >= 5'd12) ? (v - 5'd12) : v;
        return w[3:0];
    endfunction

endpackage

FILE: rtl/core/scale_note_quantizer.sv
// Top level of the scale note quantizer: config registers and four-stage pipeline.
//
// Usage:
//   Input channel (in_valid/in_ready) carries a MIDI note and a signed step
//   count. Output channel (out_valid/out_ready) returns one result per input
//   transfer: in_scale, quantized (nearest scale note, ties go low), stepped
//   (quantized moved by degrees scale steps, saturated to 0..127) and
//   scale_size. The config channel (cfg_valid/cfg_ready, cfg_index, cfg_data)
//   writes root_class (index 0) and scale_kind (index 1); it is always ready
//   and should only be used while the pipeline is empty.
//   Path: a note is registered in turn by the class, search, divide and step stages.
//   Throughput: one transfer per cycle unless stalled; every stage has its own
//   register so a new note enters each cycle while earlier ones are in flight.
//   Reset: pipeline valid bits clear, config returns to C major (root 0,
//   kind 0); no clearing pass, the block takes input right after reset.
//   Stall: when out_ready is low the stages fill up in order and in_ready
//   drops once all four hold data; nothing is lost or repeated.
`timescale 1ns / 1ps
module scale_note_quantizer (
    input  logic              clk,
    input  logic              rst_n,
    // config write channel
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic              cfg_index,
    input  logic [3:0]        cfg_data,
    // input channel
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [6:0]        note,
    input  logic signed [7:0] degrees,
    // output channel
    output logic              out_valid,
    input  logic              out_ready,
    output logic              in_scale,
    output logic [6:0]        quantized,
    output logic [6:0]        stepped,
    output logic [3:0]        scale_size
);

    logic [3:0] root_class_reg;
    logic [2:0] scale_kind_reg;

    snq_pkg::note_item_t   in_item;
    snq_pkg::class_data_t  class_data;
    snq_pkg::search_data_t search_data;
    snq_pkg::divide_data_t divide_data;
    snq_pkg::result_data_t result_data;

    logic class_valid,  class_ready;
    logic search_valid, search_ready;
    logic divide_valid, divide_ready;

    // Config writes are always accepted and land in the config registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            root_class_reg <= 4'd0;
            scale_kind_reg <= snq_pkg::KIND_MAJOR;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                snq_pkg::REG_ROOT_CLASS: root_class_reg <= cfg_data;
                snq_pkg::REG_SCALE_KIND: scale_kind_reg <= cfg_data[2:0];
                default:                 root_class_reg <= root_class_reg;
            endcase
        end
    end

    assign in_item.note    = note;
    assign in_item.degrees = degrees;

    // Stage 1: pitch class and membership
    snq_class_stage u_class (
        .clk        (clk),
        .rst_n      (rst_n),
        .root_class (root_class_reg),
        .scale_kind (scale_kind_reg),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_item),
        .out_valid  (class_valid),
        .out_ready  (class_ready),
        .out_data   (class_data)
    );

    // Stage 2: nearest scale note
    snq_search_stage u_search (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (class_valid),
        .in_ready  (class_ready),
        .in_data   (class_data),
        .out_valid (search_valid),
        .out_ready (search_ready),
        .out_data  (search_data)
    );

    // Stage 3: octave quotient of the target degree
    snq_divide_stage u_divide (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (search_valid),
        .in_ready  (search_ready),
        .in_data   (search_data),
        .out_valid (divide_valid),
        .out_ready (divide_ready),
        .out_data  (divide_data)
    );

    // Stage 4: stepped note, doubles as the output register
    snq_step_stage u_step (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (divide_valid),
        .in_ready  (divide_ready),
        .in_data   (divide_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (result_data)
    );

    assign in_scale   = result_data.in_scale;
    assign quantized  = result_data.quantized;
    assign stepped    = result_data.stepped;
    assign scale_size = result_data.scale_size;

endmodule

FILE: rtl/core/snq_class_stage.sv
// Stage 1: pitch class of the note relative to the root, scale membership.
`timescale 1ns / 1ps
module snq_class_stage (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [3:0]           root_class,
    input  logic [2:0]           scale_kind,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  snq_pkg::note_item_t  in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output snq_pkg::class_data_t out_data
);

    logic                 valid_reg;
    snq_pkg::class_data_t data_reg;
    snq_pkg::class_data_t data_next;
    logic [3:0]           root12;
    logic [3:0]           pc;
    logic [11:0]          mask;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb
    begin
        root12 = (root_class >= 4'd12) ? (root_class - 4'd12) : root_class;
        pc     = snq_pkg::note_class(in_data.note);
        mask   = snq_pkg::scale_mask(scale_kind);
        data_next.note    = in_data.note;
        data_next.degrees = in_data.degrees;
        data_next.rel     = (pc >= root12) ? (pc - root12) : (pc + 4'd12 - root12);
        data_next.in_scale = mask[data_next.rel];
        data_next.kind    = scale_kind;
        data_next.len     = snq_pkg::scale_len(scale_kind);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= data_next;
        end
    end

endmodule

FILE: rtl/core/snq_search_stage.sv
// Stage 2: nearest in-scale note, its degree and octave base.
`timescale 1ns / 1ps
module snq_search_stage (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  snq_pkg::class_data_t  in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output snq_pkg::search_data_t out_data
);

    logic                  valid_reg;
    snq_pkg::search_data_t data_reg;
    snq_pkg::search_data_t data_next;
    logic [11:0]           mask;
    logic                  found;
    logic signed [3:0]     delta;
    logic [3:0]            lo_pc;
    logic [3:0]            hi_pc;
    logic signed [8:0]     q_wide;
    logic [4:0]            qv;
    logic [3:0]            qrel;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb
    begin
        mask  = snq_pkg::scale_mask(in_data.kind);
        found = in_data.in_scale;
        delta = 4'sd0;
        lo_pc = 4'd0;
        hi_pc = 4'd0;
        // outward search, lower side wins a tie
        for (int d = 1; d <= 6; d++)
        begin
            lo_pc = snq_pkg::class_wrap(5'(in_data.rel) + 5'd12 - 5'(d));
            hi_pc = snq_pkg::class_wrap(5'(in_data.rel) + 5'(d));
            if (!found)
            begin
                if (in_data.note >= 7'(d) && mask[lo_pc])
                begin
                    delta = -4'(d);
                    found = 1'b1;
                end
                else if (8'(in_data.note) + 8'(d) <= 8'(snq_pkg::NOTE_MAX) && mask[hi_pc])
                begin
                    delta = 4'(d);
                    found = 1'b1;
                end
            end
        end

        q_wide = $signed({2'b00, in_data.note}) + 9'(delta);
        qv     = 5'(in_data.rel) + 5'd12 + 5'(delta);
        if (qv >= 5'd24)
            qrel = 4'(qv - 5'd24);
        else
            qrel = snq_pkg::class_wrap(qv);

        data_next.in_scale  = in_data.in_scale;
        data_next.quantized = q_wide[6:0];
        data_next.base      = $signed({1'b0, q_wide[6:0]}) - $signed({4'b0000, qrel});
        data_next.idx       = snq_pkg::scale_index(in_data.kind, qrel);
        data_next.degrees   = in_data.degrees;
        data_next.kind      = in_data.kind;
        data_next.len       = in_data.len;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= data_next;
        end
    end

endmodule

FILE: rtl/core/snq_divide_stage.sv
// Stage 3: target degree and its floor quotient by the scale size.
`timescale 1ns / 1ps
module snq_divide_stage (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  snq_pkg::search_data_t in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output snq_pkg::divide_data_t out_data
);

    logic                  valid_reg;
    snq_pkg::divide_data_t data_reg;
    snq_pkg::divide_data_t data_next;
    logic signed [9:0]     target;
    logic signed [9:0]     biased;
    logic [8:0]            dividend;
    logic [17:0]           prod5;
    logic [17:0]           prod6;
    logic [18:0]           prod7;
    logic [6:0]            quo;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb
    begin
        target   = $signed({7'b0000000, in_data.idx}) + 10'(in_data.degrees);
        // add 32 octaves so the quotient is a plain unsigned divide
        biased   = target + $signed({1'b0, in_data.len, 5'b00000});
        dividend = biased[8:0];
        prod5    = 18'(dividend) * 18'(snq_pkg::RECIP_5);
        prod6    = 18'(dividend) * 18'(snq_pkg::RECIP_6);
        prod7    = 19'(dividend) * 19'(snq_pkg::RECIP_7);
        unique case (in_data.len)
            4'd5:    quo = 7'(prod5 >> 10);
            4'd6:    quo = 7'(prod6 >> 10);
            4'd7:    quo = 7'(prod7 >> 11);
            default: quo = 7'(dividend >> 3);
        endcase

        data_next.in_scale  = in_data.in_scale;
        data_next.quantized = in_data.quantized;
        data_next.base      = in_data.base;
        data_next.kind      = in_data.kind;
        data_next.len       = in_data.len;
        data_next.dividend  = dividend;
        data_next.quo       = quo;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= data_next;
        end
    end

endmodule

FILE: rtl/core/snq_step_stage.sv
// Stage 4: degree remainder, table tone, octave offset and saturation.
`timescale 1ns / 1ps
module snq_step_stage (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  snq_pkg::divide_data_t in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output snq_pkg::result_data_t out_data
);

    logic                  valid_reg;
    snq_pkg::result_data_t data_reg;
    snq_pkg::result_data_t data_next;
    logic [8:0]            pos_w;
    logic [2:0]            pos;
    logic signed [7:0]     oct;
    logic [3:0]            tone;
    logic signed [10:0]    res;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb
    begin
        pos_w = in_data.dividend - 9'(9'(in_data.quo) * 9'(in_data.len));
        pos   = pos_w[2:0];
        oct   = $signed({1'b0, in_data.quo}) - $signed({1'b0, snq_pkg::OCT_BIAS});
        tone  = snq_pkg::scale_tone(in_data.kind, pos);
        res   = 11'(in_data.base) + $signed({7'b0000000, tone}) + 11'(oct) * 11'sd12;

        data_next.in_scale   = in_data.in_scale;
        data_next.quantized  = in_data.quantized;
        data_next.scale_size = in_data.len;
        if (res < 11'sd0)
            data_next.stepped = 7'd0;
        else if (res > $signed({4'b0000, snq_pkg::NOTE_MAX}))
            data_next.stepped = snq_pkg::NOTE_MAX;
        else
            data_next.stepped = res[6:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= data_next;
        end
    end

endmodule
